>>> hw/rtl/jbr_pkg.sv
package jbr_pkg;

    localparam int BUFFER_BITS = 64;
    localparam int MAX_READ    = 32;
    localparam int HELD_W      = $clog2(BUFFER_BITS + 1);
    localparam int BYTE_BITS   = 8;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SKIP_NONE   = 2'd0,
        SKIP_STUFF  = 2'd1,
        SKIP_FF     = 2'd2,
        SKIP_MARKER = 2'd3
    } skip_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] stream_byte;
        logic [5:0] bits_wanted;
    } item_t;

    typedef struct packed {
        logic [31:0] bits_value;
        logic        read_ok;
        logic        starved;
        logic        overflow;
        logic [1:0]  skip_kind;
        logic [6:0]  bits_held;
        logic [15:0] stuffing_count;
    } result_t;

    typedef struct packed {
        logic [BUFFER_BITS-1:0] bit_store;
        logic [HELD_W-1:0]      held_count;
        logic                   after_ff;
        logic [15:0]            stuff_counter;
    } reader_state_t;

    function automatic logic [BUFFER_BITS-1:0] low_mask(input logic [HELD_W-1:0] n);
        low_mask = ~({BUFFER_BITS{1'b1}} << n);
    endfunction

endpackage

>>> hw/rtl/jbr_channels.sv
interface jbr_item_if import jbr_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface jbr_result_if import jbr_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/jpeg_bit_reader_unstuff_unit.sv
// Channel  Dir  Beat payload
// item     in   opcode, stream_byte, bits_wanted
// result   out  bits_value, read_ok, starved, overflow, skip_kind, bits_held,
//               stuffing_count
//
// One item per cycle unless result stalls; items pass item_reg, then result_reg.
// The input register feeds the step logic, which updates the reader state and
// loads the result register in the same cycle.
// rst_n clears the bit store, counts and valid flags asynchronously.
// A stalled result holds both stages; item.ready drops only when both are full.
module jpeg_bit_reader_unstuff_unit import jbr_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    jbr_item_if.sink        item,
    jbr_result_if.source    result
);

    item_t         item_reg;
    logic          item_valid_reg;
    result_t       result_reg;
    result_t       result_next;
    logic          result_valid_reg;
    reader_state_t state_reg;
    reader_state_t state_next;
    logic          out_free;
    logic          advance;

    assign out_free   = !result_valid_reg || result.ready;
    assign advance    = item_valid_reg && out_free;
    assign item.ready = !item_valid_reg || out_free;

    jbr_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                item_valid_reg <= item.valid;
            end
            if (out_free)
            begin
                result_valid_reg <= item_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.payload;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

endmodule

>>> hw/rtl/jbr_step.sv
module jbr_step import jbr_pkg::*; (
    input  item_t         item,
    input  reader_state_t state,
    output reader_state_t state_next,
    output result_t       result
);

    logic [HELD_W-1:0]      want;
    logic [HELD_W-1:0]      rest;
    logic [HELD_W:0]        push_total;
    logic [BUFFER_BITS-1:0] extracted;

    always_comb
    begin
        // saturate the read length
        if (item.bits_wanted > 6'(MAX_READ))
        begin
            want = HELD_W'(MAX_READ);
        end
        else
        begin
            want = HELD_W'(item.bits_wanted);
        end
        rest       = state.held_count - want;
        push_total = (HELD_W + 1)'(state.held_count) + (HELD_W + 1)'(BYTE_BITS);
        extracted  = (state.bit_store >> rest) & low_mask(want);
    end

    always_comb
    begin
        state_next = state;
        result     = '0;

        case (opcode_t'(item.opcode))
            OP_PUSH:
            begin
                if (state.after_ff)
                begin
                    // drop the byte that follows a data 0xFF
                    state_next.after_ff = 1'b0;
                    if (item.stream_byte == 8'h00)
                    begin
                        state_next.stuff_counter = state.stuff_counter + 16'd1;
                        result.skip_kind         = SKIP_STUFF;
                    end
                    else if (item.stream_byte == 8'hFF)
                    begin
                        result.skip_kind = SKIP_FF;
                    end
                    else
                    begin
                        result.skip_kind = SKIP_MARKER;
                    end
                end
                else if (push_total > (HELD_W + 1)'(BUFFER_BITS))
                begin
                    result.overflow = 1'b1;
                end
                else
                begin
                    state_next.bit_store  = (state.bit_store << BYTE_BITS)
                                          | BUFFER_BITS'(item.stream_byte);
                    state_next.held_count = push_total[HELD_W-1:0];
                    state_next.after_ff   = (item.stream_byte == 8'hFF);
                end
            end
            OP_READ:
            begin
                if (want > state.held_count)
                begin
                    result.starved = 1'b1;
                end
                else
                begin
                    result.bits_value     = extracted[31:0];
                    result.read_ok        = 1'b1;
                    state_next.held_count = rest;
                    state_next.bit_store  = state.bit_store & low_mask(rest);
                end
            end
            OP_CLEAR:
            begin
                // round the count down to a byte boundary
                state_next.held_count = {state.held_count[HELD_W-1:3], 3'b000};
                state_next.bit_store  = state.bit_store
                                      & low_mask({state.held_count[HELD_W-1:3], 3'b000});
            end
            default:
            begin
                state_next = state;
            end
        endcase

        result.bits_held      = 7'(state_next.held_count);
        result.stuffing_count = state_next.stuff_counter;
    end

endmodule

>>> verif/tb_top.sv
module tb_top;
    import jbr_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    jbr_item_if   item_ch ();
    jbr_result_if result_ch ();

    jpeg_bit_reader_unstuff_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bit reader mirror
    logic [BUFFER_BITS-1:0] rd_store       = '0;
    int                     rd_held        = 0;
    bit                     rd_ff_pending  = 1'b0;
    logic [15:0]            rd_stuff_count = '0;

    result_t reader_results[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;

    function automatic logic [BUFFER_BITS-1:0] keep_low(input logic [BUFFER_BITS-1:0] v,
                                                      input int n);
        if (n >= BUFFER_BITS)
            return v;
        return v & ((64'd1 << n) - 64'd1);
    endfunction

    function automatic result_t bit_reader_step(input item_t it);
        result_t                r;
        int                     want;
        int                     rest;
        logic [BUFFER_BITS-1:0] taken;
        r = '0;
        case (opcode_t'(it.opcode))
            OP_PUSH:
            begin
                // A byte following a buffered 0xFF is dropped before any space check
                if (rd_ff_pending)
                begin
                    rd_ff_pending = 1'b0;
                    if (it.stream_byte == 8'h00)
                    begin
                        rd_stuff_count = rd_stuff_count + 16'd1;
                        r.skip_kind    = SKIP_STUFF;
                    end
                    else if (it.stream_byte == 8'hFF)
                        r.skip_kind = SKIP_FF;
                    else
                        r.skip_kind = SKIP_MARKER;
                end
                else if (rd_held + BYTE_BITS > BUFFER_BITS)
                    r.overflow = 1'b1;
                else
                begin
                    rd_store = (rd_store << BYTE_BITS) | BUFFER_BITS'(it.stream_byte);
                    rd_held  = rd_held + BYTE_BITS;
                    if (it.stream_byte == 8'hFF)
                        rd_ff_pending = 1'b1;
                end
            end
            OP_READ:
            begin
                want = (it.bits_wanted > MAX_READ) ? MAX_READ : int'(it.bits_wanted);
                if (want > rd_held)
                    r.starved = 1'b1;
                else
                begin
                    rest         = rd_held - want;
                    taken        = keep_low(rd_store >> rest, want);
                    r.bits_value = taken[31:0];
                    rd_held      = rest;
                    rd_store     = keep_low(rd_store, rest);
                    r.read_ok    = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                rd_held  = rd_held - (rd_held % BYTE_BITS);
                rd_store = keep_low(rd_store, rd_held);
            end
            default:
            begin
            end
        endcase
        r.bits_held      = rd_held[6:0];
        r.stuffing_count = rd_stuff_count;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (reader_results.size() == 0)
        begin
            $error("result beat with no item outstanding");
            mismatch_count++;
        end
        else
        begin
            want = reader_results.pop_front();
            compare_field("bits_value", want.bits_value, got.bits_value);
            compare_field("read_ok", 32'(want.read_ok), 32'(got.read_ok));
            compare_field("starved", 32'(want.starved), 32'(got.starved));
            compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
            compare_field("skip_kind", 32'(want.skip_kind), 32'(got.skip_kind));
            compare_field("bits_held", 32'(want.bits_held), 32'(got.bits_held));
            compare_field("stuffing_count", 32'(want.stuffing_count),
                          32'(got.stuffing_count));
        end
    endtask

    // Mirror the item first so a same-edge result still finds its entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                reader_results.push_back(bit_reader_step(item_ch.payload));
            if (result_ch.valid && result_ch.ready)
                check_result(result_ch.payload);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= sink_stall_pct);

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input opcode_t op, input logic [7:0] data_byte,
                             input logic [5:0] want);
        item_t beat;
        beat.opcode      = op;
        beat.stream_byte = data_byte;
        beat.bits_wanted = want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.payload = beat;
        item_ch.valid   = 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_reader();
        send_beat(OP_READ, 8'h00, 6'd0);
        send_beat(OP_READ, 8'hFF, 6'd1);
        send_beat(OP_CLEAR, 8'h00, 6'd0);
        send_beat(OP_NOP, 8'hFF, 6'd63);
    endtask

    task automatic test_unstuffing();
        send_beat(OP_PUSH, 8'hFF, 6'd0);
        send_beat(OP_PUSH, 8'h00, 6'd0);
        send_beat(OP_PUSH, 8'hFF, 6'd0);
        send_beat(OP_PUSH, 8'hFF, 6'd0);
        send_beat(OP_PUSH, 8'hFF, 6'd0);
        send_beat(OP_PUSH, 8'hD9, 6'd0);
        // 24 bits held: a saturated read still starves
        send_beat(OP_READ, 8'h00, 6'd63);
        send_beat(OP_READ, 8'h00, 6'd17);
        send_beat(OP_CLEAR, 8'h00, 6'd0);
    endtask

    task automatic test_buffer_full();
        int n;
        for (n = 0; n < 7; n++)
            send_beat(OP_PUSH, 8'($urandom_range(254)), 6'($urandom));
        send_beat(OP_PUSH, 8'hFF, 6'd0);
        // Full and after 0xFF: drop wins over overflow
        send_beat(OP_PUSH, 8'h00, 6'd0);
        send_beat(OP_PUSH, 8'h5A, 6'd0);
        send_beat(OP_READ, 8'h00, 6'd32);
        send_beat(OP_READ, 8'h00, 6'd32);
        send_beat(OP_READ, 8'h00, 6'd0);
    endtask

    task automatic test_random_stream(input int count, input int src_pct, input int sink_pct);
        int          n;
        int          roll;
        int          push_pct;
        logic [7:0]  data_byte;
        logic [5:0]  want;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (n = 0; n < count; n++)
        begin
            push_pct  = (rd_held < 16) ? 70 : ((rd_held > 48) ? 30 : 50);
            data_byte = 8'($urandom);
            want      = 6'($urandom);
            if ($urandom_range(99) < push_pct)
            begin
                roll = $urandom_range(99);
                // Favor well-formed stuffing right after a data 0xFF
                if (rd_ff_pending)
                    data_byte = (roll < 70) ? 8'h00 : ((roll < 80) ? 8'hFF : data_byte);
                else if (roll < 12)
                    data_byte = 8'hFF;
                send_beat(OP_PUSH, data_byte, want);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 84)
                begin
                    roll = $urandom_range(99);
                    if (roll < 6)
                        want = 6'd0;
                    else if (roll < 70)
                        want = 6'($urandom_range(16, 1));
                    else if (roll < 90)
                        want = 6'($urandom_range(32, 17));
                    else
                        want = 6'($urandom_range(63, 33));
                    send_beat(OP_READ, data_byte, want);
                end
                else if (roll < 94)
                    send_beat(OP_CLEAR, data_byte, want);
                else
                    send_beat(OP_NOP, data_byte, want);
            end
        end
    endtask

    task automatic test_drain();
        item_ch.valid  = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (reader_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.payload  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_reader();
        test_unstuffing();
        test_buffer_full();
        test_random_stream(490, 0, 0);
        test_random_stream(490, 80, 0);
        test_random_stream(490, 0, 80);
        test_random_stream(490, 38, 38);
        test_drain();

        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
